### rtl/dgas_pkg.sv
// Shared types, constants and helper functions of the digamma series block.
`default_nettype none

package dgas_pkg;

  localparam int MAG_W = 51;
  localparam int SUM_W = 53;
  localparam int DIV_STAGES = 49;
  localparam int LOG_ROUNDS = 32;
  localparam int LOG_LAT = LOG_ROUNDS + 2;
  localparam int QMUL_LAT = 2;
  localparam int HORNER_LAT = 3;
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW = 2;

  localparam logic [MAG_W-1:0] CLAMP_MAG = {1'b1, 50'd0};
  localparam logic [MAG_W-1:0] LN2_Q32 = 51'd2977044472;
  localparam logic [31:0] X_ONE = 32'h0001_0000;
  localparam logic [31:0] NEG_EULER_Q24 = 32'hFF6C_3B98;
  localparam logic [31:0] PSI_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] PSI_MIN = 32'h8000_0000;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sm_t;

  typedef struct packed {
    logic [31:0] x;
    logic        one;
  } fe_item_t;

  function automatic sm_t coef_sm(input logic [2:0] k);
    sm_t o;
    o.neg = 1'b0;
    o.mag = '0;
    case (k)
      3'd0: begin
        o.neg = 1'b1;
        o.mag = 51'd357913941;
      end
      3'd1: begin
        o.neg = 1'b0;
        o.mag = 51'd35791394;
      end
      3'd2: begin
        o.neg = 1'b1;
        o.mag = 51'd17043521;
      end
      3'd3: begin
        o.neg = 1'b0;
        o.mag = 51'd17895697;
      end
      3'd4: begin
        o.neg = 1'b1;
        o.mag = 51'd32537631;
      end
      3'd5: begin
        o.neg = 1'b0;
        o.mag = 51'd90592869;
      end
      3'd6: begin
        o.neg = 1'b1;
        o.mag = 51'd357913941;
      end
      default: begin
        o.neg = 1'b0;
        o.mag = '0;
      end
    endcase
    return o;
  endfunction

  function automatic logic signed [SUM_W-1:0] sm_to_s(input sm_t v);
    logic signed [SUM_W-1:0] u;
    u = signed'({2'b00, v.mag});
    return v.neg ? -u : u;
  endfunction

  function automatic sm_t s_to_sm(input logic signed [SUM_W-1:0] s);
    sm_t o;
    logic [SUM_W-1:0] m;
    m = s[SUM_W-1] ? unsigned'(-s) : unsigned'(s);
    o.neg = s[SUM_W-1];
    o.mag = (m > {2'b00, CLAMP_MAG}) ? CLAMP_MAG : m[MAG_W-1:0];
    return o;
  endfunction

endpackage

`default_nettype wire

### rtl/dgas_front.sv
// Front end: fixes up the argument, flags the exact-one case and queues items.
`default_nettype none

module dgas_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [31:0]       x_value,
  output logic                   full,
  output dgas_pkg::fe_item_t     head,
  output logic                   head_vld,
  input  wire logic              head_pop
);
  import dgas_pkg::*;

  fe_item_t         q_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_r, wr_nxt;
  logic [FQ_AW-1:0] rd_r, rd_nxt;
  logic [FQ_AW:0]   cnt_r, cnt_nxt;
  logic             push_ok, pop_ok;
  fe_item_t         item;

  always_comb begin
    item.x   = (x_value == 32'd0) ? 32'd1 : x_value;
    item.one = (item.x == X_ONE);
  end

  assign full     = (cnt_r == (FQ_AW+1)'(FQ_DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head     = q_r[rd_r];
  assign push_ok  = push && !full;
  assign pop_ok   = head_pop && head_vld;

  always_comb begin
    wr_nxt  = push_ok ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop_ok ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_r] <= item;
    end
  end

endmodule

`default_nettype wire

### rtl/dgas_qmul.sv
// Two-stage Q.32 sign-magnitude multiplier with rounding and magnitude clamp.
`default_nettype none

module dgas_qmul (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire dgas_pkg::sm_t a,
  input  wire dgas_pkg::sm_t b,
  output dgas_pkg::sm_t     p
);
  import dgas_pkg::*;

  logic [63:0]  p00_r;
  logic [50:0]  p01_r, p10_r;
  logic [37:0]  p11_r;
  logic         neg_r;
  sm_t          p_r;
  logic [101:0] full;
  logic [69:0]  rnd;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= a.mag[31:0] * b.mag[31:0];
      p01_r <= a.mag[31:0] * b.mag[50:32];
      p10_r <= a.mag[50:32] * b.mag[31:0];
      p11_r <= a.mag[50:32] * b.mag[50:32];
      neg_r <= a.neg ^ b.neg;
    end
  end

  always_comb begin
    full = {38'd0, p00_r} + {19'd0, p01_r, 32'd0} + {19'd0, p10_r, 32'd0}
         + {p11_r, 64'd0} + {70'd0, 1'b1, 31'd0};
    rnd  = full[101:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r.neg <= neg_r;
      p_r.mag <= (rnd > {19'd0, CLAMP_MAG}) ? CLAMP_MAG : rnd[MAG_W-1:0];
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

### rtl/dgas_div.sv
// Pipelined restoring divider giving 2^48/x and 2^47/x rounded, one bit a stage.
`default_nettype none

module dgas_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] x,
  output logic [48:0]      recip,
  output logic [48:0]      half
);
  import dgas_pkg::*;

  logic [31:0] x_p   [DIV_STAGES+1];
  logic [31:0] rm1_p [DIV_STAGES+1];
  logic [31:0] rm2_p [DIV_STAGES+1];
  logic [48:0] q1_p  [DIV_STAGES+1];
  logic [48:0] q2_p  [DIV_STAGES+1];

  assign x_p[0]   = x;
  assign rm1_p[0] = '0;
  assign rm2_p[0] = '0;
  assign q1_p[0]  = '0;
  assign q2_p[0]  = '0;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int BIT = DIV_STAGES - 1 - s;
    logic        d1, d2, ge1, ge2;
    logic [32:0] t1, t2, df1, df2;
    logic [31:0] x_r, rm1_r, rm2_r;
    logic [48:0] q1_r, q2_r;

    if (BIT == 48) begin : g_d1_top
      assign d1 = 1'b1;
    end else if (BIT <= 30) begin : g_d1_low
      assign d1 = x_p[s][BIT+1];
    end else begin : g_d1_zero
      assign d1 = 1'b0;
    end

    if (BIT == 47) begin : g_d2_top
      assign d2 = 1'b1;
    end else if (BIT <= 30) begin : g_d2_low
      assign d2 = x_p[s][BIT+1];
    end else begin : g_d2_zero
      assign d2 = 1'b0;
    end

    always_comb begin
      t1  = {rm1_p[s], d1};
      t2  = {rm2_p[s], d2};
      df1 = t1 - {1'b0, x_p[s]};
      df2 = t2 - {1'b0, x_p[s]};
      ge1 = (t1 >= {1'b0, x_p[s]});
      ge2 = (t2 >= {1'b0, x_p[s]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r   <= x_p[s];
        rm1_r <= ge1 ? df1[31:0] : t1[31:0];
        rm2_r <= ge2 ? df2[31:0] : t2[31:0];
        q1_r  <= {q1_p[s][47:0], ge1};
        q2_r  <= {q2_p[s][47:0], ge2};
      end
    end

    assign x_p[s+1]   = x_r;
    assign rm1_p[s+1] = rm1_r;
    assign rm2_p[s+1] = rm2_r;
    assign q1_p[s+1]  = q1_r;
    assign q2_p[s+1]  = q2_r;
  end

  assign recip = q1_p[DIV_STAGES];
  assign half  = q2_p[DIV_STAGES];

endmodule

`default_nettype wire

### rtl/dgas_log.sv
// Pipelined binary logarithm by repeated squaring, one fraction bit a stage.
`default_nettype none

module dgas_log (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] x,
  output dgas_pkg::sm_t    log2v
);
  import dgas_pkg::*;

  logic [31:0] m_p [LOG_ROUNDS+1];
  logic [4:0]  p_p [LOG_ROUNDS+1];
  logic [31:0] f_p [LOG_ROUNDS+1];
  logic [31:0] m0_r, f0_r;
  logic [4:0]  p0_r;
  logic [4:0]  top;
  logic [4:0]  e;
  sm_t         out_r;

  always_comb begin
    top = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        top = 5'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= top;
      m0_r <= x << (5'd31 - top);
      f0_r <= '0;
    end
  end

  assign m_p[0] = m0_r;
  assign p_p[0] = p0_r;
  assign f_p[0] = f0_r;

  for (genvar s = 0; s < LOG_ROUNDS; s++) begin : g_round
    logic [63:0] sq;
    logic [32:0] sh;
    logic [31:0] m_r, f_r;
    logic [4:0]  p_r;

    always_comb begin
      sq = m_p[s] * m_p[s];
      sh = sq[63:31];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r <= sh[32] ? sh[32:1] : sh[31:0];
        f_r <= {f_p[s][30:0], sh[32]};
        p_r <= p_p[s];
      end
    end

    assign m_p[s+1] = m_r;
    assign f_p[s+1] = f_r;
    assign p_p[s+1] = p_r;
  end

  always_comb begin
    e = p_p[LOG_ROUNDS] - 5'd16;
    if (!p_p[LOG_ROUNDS][4]) begin
      e = 5'd16 - p_p[LOG_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (p_p[LOG_ROUNDS][4]) begin
        out_r.neg <= 1'b0;
        out_r.mag <= MAG_W'({e[3:0], f_p[LOG_ROUNDS]});
      end else begin
        out_r.neg <= 1'b1;
        out_r.mag <= MAG_W'({e, 32'd0} - {5'd0, f_p[LOG_ROUNDS]});
      end
    end
  end

  assign log2v = out_r;

endmodule

`default_nettype wire

### rtl/dgas_back.sv
// Back end: reciprocal, log, Horner series, final sum and output register.
`default_nettype none

module dgas_back #(
  parameter int SERIES_TERMS = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire dgas_pkg::fe_item_t head,
  input  wire logic          head_vld,
  output logic               head_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic signed [31:0] psi_value,
  output logic               saturated
);
  import dgas_pkg::*;

  localparam int NT    = SERIES_TERMS;
  localparam int L_R2  = DIV_STAGES + QMUL_LAT;
  localparam int L_SER = L_R2 + HORNER_LAT * (NT - 1) + QMUL_LAT;
  localparam int L_LN  = LOG_LAT + QMUL_LAT;
  localparam int D_H   = L_SER - DIV_STAGES;
  localparam int D_L   = L_SER - L_LN;

  logic                    en;
  logic [L_SER:0]          vld_r, one_r;
  logic [48:0]             recip, half;
  logic [48:0]             hd_r [D_H];
  sm_t                     log2v, ln_v, r_sm, r2, ser;
  sm_t                     ld_r [D_L];
  sm_t                     h_sm [NT];
  sm_t                     r2_d [NT];
  sm_t                     ln2_sm;
  logic signed [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0]        amag, qsum;
  logic [44:0]             qv;
  logic [31:0]             psi_nxt, psi_r;
  logic                    sat_nxt, sat_r, out_vld_r;

  assign en       = !out_vld_r || pop;
  assign head_pop = en && head_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[L_SER-1:0], head_vld};
      out_vld_r <= vld_r[L_SER];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      one_r <= {one_r[L_SER-1:0], head.one};
    end
  end

  dgas_div u_div (
    .clk   (clk),
    .en    (en),
    .x     (head.x),
    .recip (recip),
    .half  (half)
  );

  dgas_log u_log (
    .clk   (clk),
    .en    (en),
    .x     (head.x),
    .log2v (log2v)
  );

  assign ln2_sm.neg = 1'b0;
  assign ln2_sm.mag = LN2_Q32;

  dgas_qmul u_ln (
    .clk (clk),
    .en  (en),
    .a   (log2v),
    .b   (ln2_sm),
    .p   (ln_v)
  );

  assign r_sm.neg = 1'b0;
  assign r_sm.mag = {2'b00, recip};

  dgas_qmul u_r2 (
    .clk (clk),
    .en  (en),
    .a   (r_sm),
    .b   (r_sm),
    .p   (r2)
  );

  assign h_sm[0] = coef_sm(3'(NT - 1));
  assign r2_d[0] = r2;

  for (genvar i = 0; i < NT - 1; i++) begin : g_horner
    sm_t prod;
    sm_t h_r;
    sm_t rd_r [HORNER_LAT];

    dgas_qmul u_mul (
      .clk (clk),
      .en  (en),
      .a   (r2_d[i]),
      .b   (h_sm[i]),
      .p   (prod)
    );

    always_ff @(posedge clk) begin
      if (en) begin
        rd_r[0] <= r2_d[i];
        for (int j = 1; j < HORNER_LAT; j++) begin
          rd_r[j] <= rd_r[j-1];
        end
        h_r <= s_to_sm(sm_to_s(coef_sm(3'(NT - 2 - i))) + sm_to_s(prod));
      end
    end

    assign h_sm[i+1] = h_r;
    assign r2_d[i+1] = rd_r[HORNER_LAT-1];
  end

  dgas_qmul u_ser (
    .clk (clk),
    .en  (en),
    .a   (r2_d[NT-1]),
    .b   (h_sm[NT-1]),
    .p   (ser)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      hd_r[0] <= half;
      for (int j = 1; j < D_H; j++) begin
        hd_r[j] <= hd_r[j-1];
      end
      ld_r[0] <= ln_v;
      for (int j = 1; j < D_L; j++) begin
        ld_r[j] <= ld_r[j-1];
      end
      sum_r <= sm_to_s(ld_r[D_L-1]) - signed'({4'd0, hd_r[D_H-1]}) + sm_to_s(ser);
    end
  end

  always_comb begin
    amag = sum_r[SUM_W-1] ? unsigned'(-sum_r) : unsigned'(sum_r);
    qsum = amag + SUM_W'(128);
    qv   = qsum[52:8];
    sat_nxt = 1'b0;
    if (one_r[L_SER]) begin
      psi_nxt = NEG_EULER_Q24;
    end else if (sum_r[SUM_W-1]) begin
      if (qv > {13'd0, 1'b1, 31'd0}) begin
        psi_nxt = PSI_MIN;
        sat_nxt = 1'b1;
      end else begin
        psi_nxt = 32'd0 - qv[31:0];
      end
    end else begin
      if (qv > {14'd0, {31{1'b1}}}) begin
        psi_nxt = PSI_MAX;
        sat_nxt = 1'b1;
      end else begin
        psi_nxt = qv[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      psi_r <= psi_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign empty     = !out_vld_r;
  assign psi_value = signed'(psi_r);
  assign saturated = sat_r;

endmodule

`default_nettype wire

### rtl/digamma_asymptotic_series.sv
// Top level of the digamma asymptotic series unit.
// Throughput: one item per cycle while no result is held at the output;
// the 49-stage reciprocal divider heads the longest path.
// A held result freezes the back pipeline; a four-entry input queue absorbs the stall.
// Synchronous active-low reset empties the queue and clears all valid bits.
`default_nettype none

module digamma_asymptotic_series #(
  parameter int SERIES_TERMS = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [31:0]   in_x_value,
  output logic               full,
  output logic               empty,
  input  wire logic          pop,
  output logic signed [31:0] out_psi_value,
  output logic               out_saturated
);
  import dgas_pkg::*;

  fe_item_t head;
  logic     head_vld;
  logic     head_pop;

  dgas_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .x_value  (in_x_value),
    .full     (full),
    .head     (head),
    .head_vld (head_vld),
    .head_pop (head_pop)
  );

  dgas_back #(
    .SERIES_TERMS (SERIES_TERMS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_vld  (head_vld),
    .head_pop  (head_pop),
    .pop       (pop),
    .empty     (empty),
    .psi_value (out_psi_value),
    .saturated (out_saturated)
  );

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queue not cleared by reset");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_saturated) |->
      (out_psi_value == PSI_MAX || out_psi_value == PSI_MIN))
    else $error("saturated item is not at an output limit");

endmodule

`default_nettype wire

### dv/tb_top.sv
// Testbench for the digamma asymptotic series unit: directed and random arguments under idling.
`timescale 1ns / 1ps

module tb_top;
  localparam int TERMS = 7;
  localparam logic [63:0] MAG_LIMIT = 64'd1 << 50;
  localparam logic signed [63:0] LN2_Q32 = 64'sd2977044472;
  localparam logic [31:0] ARG_ONE = 32'h0001_0000;
  localparam logic signed [31:0] NEG_EULER = -32'sd9684072;

  typedef struct packed {
    logic signed [31:0] psi;
    logic               sat;
  } psi_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic [31:0]        in_x_value = '0;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [31:0] out_psi_value;
  logic               out_saturated;

  psi_result_t psi_expected[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int saturated_seen = 0;

  digamma_asymptotic_series #(.SERIES_TERMS(TERMS)) DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .in_x_value(in_x_value), .full(full),
    .empty(empty), .pop(pop), .out_psi_value(out_psi_value), .out_saturated(out_saturated)
  );

  always #5 clk = ~clk;

  function automatic logic signed [63:0] clamp_mag(input logic [63:0] m, input logic neg);
    logic [63:0] c;
    c = (m > MAG_LIMIT) ? MAG_LIMIT : m;
    return neg ? -$signed(c) : $signed(c);
  endfunction

  function automatic logic signed [63:0] q32_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [63:0] ua, ub;
    logic [127:0] pr;
    logic neg;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    neg = a[63] != b[63];
    pr = {64'd0, ua} * {64'd0, ub} + (128'd1 << 31);
    if (pr[127:96] != 0) return clamp_mag(MAG_LIMIT, neg);
    return clamp_mag(pr[95:32], neg);
  endfunction

  function automatic logic signed [63:0] q32_sat_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    return clamp_mag(s[63] ? -s : s, s[63]);
  endfunction

  function automatic logic signed [63:0] series_coef(input int k);
    case (k)
      0: return -64'sd357913941;
      1: return 64'sd35791394;
      2: return -64'sd17043521;
      3: return 64'sd17895697;
      4: return -64'sd32537631;
      5: return 64'sd90592869;
      default: return -64'sd357913941;
    endcase
  endfunction

  function automatic logic signed [63:0] natural_log_q32(input logic [31:0] x);
    int p;
    logic [63:0] m, frac;
    logic signed [63:0] lg;
    p = 31;
    frac = '0;
    while (p > 0 && !x[p]) p--;
    m = ({32'd0, x} << (31 - p)) & 64'hFFFF_FFFF;
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    lg = $signed(64'(p - 16)) * 64'sd4294967296 + $signed(frac);
    return q32_mul(lg, LN2_Q32);
  endfunction

  function automatic psi_result_t digamma_of(input logic [31:0] x_in);
    logic [63:0] x, mag, q;
    logic signed [63:0] r, half, r2, h, series, sum;
    psi_result_t o;
    x = (x_in == 0) ? 64'd1 : {32'd0, x_in};
    o.sat = 1'b0;
    if (x == ARG_ONE) begin
      o.psi = NEG_EULER;
      return o;
    end
    r = ((64'd1 << 48) + (x >> 1)) / x;
    half = ((64'd1 << 47) + (x >> 1)) / x;
    r2 = q32_mul(r, r);
    h = series_coef(TERMS - 1);
    for (int k = TERMS - 2; k >= 0; k--) h = q32_sat_add(series_coef(k), q32_mul(r2, h));
    series = q32_mul(r2, h);
    sum = natural_log_q32(x[31:0]) - half + series;
    mag = sum[63] ? -sum : sum;
    q = (mag + 64'd128) >> 8;
    if (sum[63]) begin
      if (q > (64'd1 << 31)) begin
        q = 64'd1 << 31;
        o.sat = 1'b1;
      end
      o.psi = -$signed(q[31:0]);
    end else begin
      if (q > (64'd1 << 31) - 1) begin
        q = (64'd1 << 31) - 1;
        o.sat = 1'b1;
      end
      o.psi = q[31:0];
    end
    return o;
  endfunction

  task automatic send_arg(input logic [31:0] x);
    int gap;
    push <= 1'b1;
    in_x_value <= x;
    @(posedge clk);
    while (full) @(posedge clk);
    psi_expected.push_back(digamma_of(x));
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      in_x_value <= $urandom;
      gap = $urandom_range(6, 1);
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] random_arg();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(31);
      2: return ARG_ONE + $urandom_range(8192) - 4096;
      default: return 32'd1 << $urandom_range(31);
    endcase
  endfunction

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (psi_expected.size() == 0) begin
        $display("%0t: unexpected result psi=%0d sat=%0b", $time, out_psi_value,
                 out_saturated);
        errors++;
      end else begin
        psi_result_t e;
        e = psi_expected.pop_front();
        if (out_psi_value !== e.psi) begin
          $display("%0t: psi_value expected %0d actual %0d", $time, e.psi, out_psi_value);
          errors++;
        end
        if (out_saturated !== e.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, e.sat, out_saturated);
          errors++;
        end
        if (out_saturated === 1'b1) saturated_seen++;
        results_checked++;
      end
    end
  end

  task automatic run_random(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_arg(random_arg());
    push <= 1'b0;
  endtask

  task automatic test_extremes();
    logic [31:0] args[$];
    args = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd255, 32'h0000_1000, 32'h0000_8000,
             32'h0000_FFFF, ARG_ONE, 32'h0001_0001, 32'h0001_8000, 32'h0002_0000,
             32'h000A_0000, 32'h0100_0000, 32'h5555_5555, 32'hAAAA_AAAA,
             32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0400};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (args[i]) send_arg(args[i]);
    push <= 1'b0;
  endtask

  task automatic test_no_idle();
    run_random(100, 0, 0);
  endtask

  task automatic test_sender_idle();
    run_random(100, 80, 0);
  endtask

  task automatic test_receiver_stall();
    run_random(100, 0, 80);
  endtask

  task automatic test_both_idle();
    run_random(100, 38, 38);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    recv_stall_pct = 0;
    while (psi_expected.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d arguments over five phases; checked %0d results, %0d saturated.",
             items_sent, results_checked, saturated_seen);
    if (errors == 0 && psi_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule
